// ===== sv/svsw_pkg.sv =====
// Package with the types and constants of the SMBIOS vendor string walker.
`default_nettype none

package svsw_pkg;

  // Register reset value and the special codes of the structure table.
  localparam logic [8:0] MAX_LEN_RESET = 9'd64;
  localparam logic [7:0] TYPE_END      = 8'd127;
  localparam logic [7:0] TYPE_BIOS     = 8'd0;
  localparam logic [7:0] MIN_LENGTH    = 8'd4;
  localparam logic [7:0] MIN_BIOS_LEN  = 8'd5;
  localparam logic [7:0] OFS_LENGTH    = 8'd1;
  localparam logic [7:0] OFS_VENDOR    = 8'd4;

  // Where the walker stands inside the current structure.
  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_FORMAT    = 3'd1,
    PH_SKIP      = 3'd2,
    PH_STR_START = 3'd3,
    PH_STR_IN    = 3'd4,
    PH_EMIT      = 3'd5
  } walk_phase_t;

  // Complete walker state, carried between the step logic and the top level.
  typedef struct packed {
    walk_phase_t phase;
    logic [7:0]  cur_type;
    logic [7:0]  cur_len;
    logic [7:0]  offset;
    logic [7:0]  wanted;
    logic [7:0]  str_cnt;
    logic        prev_zero;
    logic [8:0]  chars_sent;
    logic        finished;
  } walk_state_t;

  // One result word.
  typedef struct packed {
    logic [7:0] vendor_char;
    logic       char_valid;
    logic       done_res;
    logic       found;
  } walk_result_t;

  // State after reset and after the final byte of a table.
  localparam walk_state_t WALK_REARM = '{
    phase:      PH_HEADER,
    cur_type:   8'd0,
    cur_len:    8'd0,
    offset:     8'd0,
    wanted:     8'd0,
    str_cnt:    8'd1,
    prev_zero:  1'b0,
    chars_sent: 9'd0,
    finished:   1'b0
  };

endpackage

`default_nettype wire

// ===== sv/svsw_if.sv =====
// Handshake interfaces for the table byte channel and the result channel.
`default_nettype none

interface svsw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       table_last;

  modport source (output valid, output table_byte, output table_last, input ready);
  modport sink   (input valid, input table_byte, input table_last, output ready);
endinterface

interface svsw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] vendor_char;
  logic       char_valid;
  logic       done_res;
  logic       found;

  modport source (output valid, output vendor_char, output char_valid,
                  output done_res, output found, input ready);
  modport sink   (input valid, input vendor_char, input char_valid,
                  input done_res, input found, output ready);
endinterface

`default_nettype wire

// ===== sv/svsw_step.sv =====
// Combinational next-state and result logic for one table byte.
`default_nettype none

module svsw_step (
  input  var svsw_pkg::walk_state_t  st,
  input  var logic [7:0]             table_byte,
  input  var logic                   table_last,
  input  var logic [8:0]             max_len,
  output svsw_pkg::walk_state_t      st_nxt,
  output logic                       have_res,
  output svsw_pkg::walk_result_t     res
);

  // One byte of a string set that is being skipped: two zeros in a row end it.
  function automatic svsw_pkg::walk_state_t skip_byte(svsw_pkg::walk_state_t s,
                                                       logic [7:0] b);
    svsw_pkg::walk_state_t r;
    r = s;
    if (b == 8'd0) begin
      if (s.prev_zero) begin
        r.phase     = svsw_pkg::PH_HEADER;
        r.offset    = 8'd0;
        r.prev_zero = 1'b0;
      end else begin
        r.prev_zero = 1'b1;
      end
    end else begin
      r.prev_zero = 1'b0;
    end
    return r;
  endfunction

  logic       done;
  logic       fnd;
  logic       cv;
  logic [7:0] ch;
  logic [7:0] len_v;
  logic [7:0] wanted_v;
  logic [8:0] limit;
  logic [8:0] sent_inc;

  always_comb begin
    st_nxt   = st;
    have_res = 1'b0;
    done     = 1'b0;
    fnd      = 1'b0;
    cv       = 1'b0;
    ch       = 8'd0;
    len_v    = st.cur_len;
    wanted_v = st.wanted;
    limit    = max_len - 9'd1;
    sent_inc = 9'd0;

    if (st.finished) begin
      // Search over: wait for the end of the table.
      if (table_last) begin
        st_nxt = svsw_pkg::WALK_REARM;
      end
    end else begin
      if (max_len == 9'd0) begin
        have_res = 1'b1;
        done     = 1'b1;
      end else begin
        // Walk phase transitions.
        case (st.phase)
          svsw_pkg::PH_FORMAT: begin
            if (st.offset == svsw_pkg::OFS_LENGTH) begin
              len_v          = table_byte;
              st_nxt.cur_len = table_byte;
            end
            if (st.offset == svsw_pkg::OFS_LENGTH && table_byte < svsw_pkg::MIN_LENGTH) begin
              have_res = 1'b1;
              done     = 1'b1;
            end else begin
              if (st.offset == svsw_pkg::OFS_VENDOR && st.cur_type == svsw_pkg::TYPE_BIOS) begin
                wanted_v      = table_byte;
                st_nxt.wanted = table_byte;
              end
              if ({1'b0, st.offset} + 9'd1 >= {1'b0, len_v}) begin
                st_nxt.prev_zero = 1'b0;
                st_nxt.str_cnt   = 8'd1;
                if (st.cur_type == svsw_pkg::TYPE_BIOS && len_v >= svsw_pkg::MIN_BIOS_LEN &&
                    wanted_v != 8'd0) begin
                  st_nxt.phase = svsw_pkg::PH_STR_START;
                end else begin
                  st_nxt.phase = svsw_pkg::PH_SKIP;
                end
              end else begin
                st_nxt.offset = st.offset + 8'd1;
              end
            end
          end
          svsw_pkg::PH_SKIP: begin
            st_nxt = skip_byte(st, table_byte);
          end
          svsw_pkg::PH_STR_START: begin
            if (table_byte == 8'd0) begin
              st_nxt       = st;
              st_nxt.phase = svsw_pkg::PH_SKIP;
              st_nxt       = skip_byte(st_nxt, table_byte);
            end else if (st.str_cnt == st.wanted) begin
              st_nxt.phase      = svsw_pkg::PH_EMIT;
              st_nxt.chars_sent = 9'd0;
            end else begin
              st_nxt.phase     = svsw_pkg::PH_STR_IN;
              st_nxt.prev_zero = 1'b0;
            end
          end
          svsw_pkg::PH_STR_IN: begin
            if (table_byte == 8'd0) begin
              st_nxt.str_cnt   = st.str_cnt + 8'd1;
              st_nxt.phase     = svsw_pkg::PH_STR_START;
              st_nxt.prev_zero = 1'b1;
            end else begin
              st_nxt.prev_zero = 1'b0;
            end
          end
          svsw_pkg::PH_EMIT: begin
            st_nxt = st;
          end
          default: begin
            // Header: the type byte of a new structure.
            st_nxt.cur_type = table_byte;
            if (table_byte == svsw_pkg::TYPE_END) begin
              have_res = 1'b1;
              done     = 1'b1;
            end else begin
              st_nxt.offset = 8'd1;
              st_nxt.phase  = svsw_pkg::PH_FORMAT;
            end
          end
        endcase

        // Emission of the selected string, including its first character.
        if (st_nxt.phase == svsw_pkg::PH_EMIT && !have_res) begin
          have_res = 1'b1;
          fnd      = 1'b1;
          if (table_byte == 8'd0 || st_nxt.chars_sent >= limit) begin
            done = 1'b1;
          end else begin
            cv                = 1'b1;
            ch                = table_byte;
            sent_inc          = st_nxt.chars_sent + 9'd1;
            st_nxt.chars_sent = sent_inc;
            done              = (sent_inc >= limit) || table_last;
          end
        end
      end

      // Table end without any other result.
      if (!have_res && table_last) begin
        have_res = 1'b1;
        done     = 1'b1;
      end

      // A final result ends the search or, on the last byte, rearms.
      if (have_res && done) begin
        if (table_last) begin
          st_nxt = svsw_pkg::WALK_REARM;
        end else begin
          st_nxt.finished = 1'b1;
        end
      end
    end

    res.vendor_char = ch;
    res.char_valid  = cv;
    res.done_res    = done;
    res.found       = done & fnd;
  end

endmodule

`default_nettype wire

// ===== sv/smbios_vendor_string_walk.sv =====
// Top level of the SMBIOS vendor string walker.
`default_nettype none

// The walker takes the SMBIOS structure table one word (byte) per cycle and
// gives zero or one result word per byte. Each byte is decided in the same
// cycle it is accepted, by small compares on the walker state, and its result
// goes to an output register; a byte is accepted whenever that register is
// empty or is being taken, so the sustained rate is one byte per cycle while
// results are taken, and a result is out in the cycle after its byte. There is
// no clearing pass after reset. cfg_wdata sets the output buffer size: at most
// that minus one characters of the vendor string are emitted. It must be
// written only while the walker is idle; the block does not enforce it.
module smbios_vendor_string_walk (
  input  wire logic        clk,
  input  wire logic        rst_n,
  svsw_in_if.sink          in_ch,
  svsw_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata
);

  svsw_pkg::walk_state_t  st_r;
  svsw_pkg::walk_state_t  st_nxt;
  svsw_pkg::walk_result_t res;
  svsw_pkg::walk_result_t res_r;
  logic                   have_res;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [8:0]             max_len_r;
  logic                   in_fire;

  // Per-byte walker logic.
  svsw_step u_step (
    .st         (st_r),
    .table_byte (in_ch.table_byte),
    .table_last (in_ch.table_last),
    .max_len    (max_len_r),
    .st_nxt     (st_nxt),
    .have_res   (have_res),
    .res        (res)
  );

  // Handshake: the output register parts the two sides.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_fire && have_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= svsw_pkg::WALK_REARM;
      out_valid_r <= 1'b0;
      max_len_r   <= svsw_pkg::MAX_LEN_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        st_r <= st_nxt;
      end
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_fire && have_res) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.vendor_char = res_r.vendor_char;
  assign out_ch.char_valid  = res_r.char_valid;
  assign out_ch.done_res    = res_r.done_res;
  assign out_ch.found       = res_r.found;

endmodule

`default_nettype wire

// ===== tb/smbios_vendor_string_walk_test.sv =====
`timescale 1ns / 100ps
// Testbench for the SMBIOS vendor string walker: directed and random tables on a scoreboard.

module smbios_vendor_string_walk_test;

  localparam int PHASE_WORDS     = 165;
  localparam int PHASE_COUNT     = 7;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 8;
  localparam int PRESSURE_CYCLES = 120;
  localparam int LONG_STRING     = 260;
  localparam int RESET_CYCLES    = 12;
  localparam int RUN_LIMIT_NS    = 2_000_000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [8:0] cfg_wdata;
  bit         pressure_req = 1'b0;
  logic [7:0] tbl[$];

  svsw_in_if  in_ch();
  svsw_out_if out_ch();

  smbios_vendor_string_walk dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Scoreboard: walks each accepted table byte and keeps the result words still owed.
  class vendor_scoreboard;
    svsw_pkg::walk_state_t  st;
    logic [8:0]             max_len;
    svsw_pkg::walk_result_t expected_words[$];
    int unsigned            walked;
    int unsigned            fails;

    function new();
      st = svsw_pkg::WALK_REARM;
      max_len = svsw_pkg::MAX_LEN_RESET;
      walked = 0;
      fails = 0;
    endfunction

    function void set_max_len(logic [8:0] v);
      max_len = v;
    endfunction

    // Inside a string set, two zeros in a row close the structure.
    function void skip_set_byte(logic [7:0] b);
      if (b != 8'd0) begin
        st.prev_zero = 1'b0;
      end else if (st.prev_zero) begin
        st.phase = svsw_pkg::PH_HEADER;
        st.offset = 8'd0;
        st.prev_zero = 1'b0;
      end else begin
        st.prev_zero = 1'b1;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      svsw_pkg::walk_result_t r;
      logic                   have;
      logic                   hit;
      logic [8:0]             limit;
      r = '0;
      have = 1'b0;
      hit = 1'b0;
      walked++;

      // After the search has ended, only the final byte matters.
      if (st.finished) begin
        if (last) st = svsw_pkg::WALK_REARM;
        return;
      end

      if (max_len == 9'd0) begin
        have = 1'b1;
        r.done_res = 1'b1;
      end else begin
        case (st.phase)
          svsw_pkg::PH_FORMAT: begin
            if (st.offset == svsw_pkg::OFS_LENGTH) st.cur_len = b;
            if (st.offset == svsw_pkg::OFS_LENGTH && b < svsw_pkg::MIN_LENGTH) begin
              have = 1'b1;
              r.done_res = 1'b1;
            end else begin
              if (st.offset == svsw_pkg::OFS_VENDOR &&
                  st.cur_type == svsw_pkg::TYPE_BIOS) st.wanted = b;
              if ({1'b0, st.offset} + 9'd1 >= {1'b0, st.cur_len}) begin
                st.prev_zero = 1'b0;
                st.str_cnt = 8'd1;
                if (st.cur_type == svsw_pkg::TYPE_BIOS && st.cur_len >= svsw_pkg::MIN_BIOS_LEN &&
                    st.wanted != 8'd0) begin
                  st.phase = svsw_pkg::PH_STR_START;
                end else begin
                  st.phase = svsw_pkg::PH_SKIP;
                end
              end else begin
                st.offset = st.offset + 8'd1;
              end
            end
          end
          svsw_pkg::PH_SKIP: begin
            skip_set_byte(b);
          end
          svsw_pkg::PH_STR_START: begin
            if (b == 8'd0) begin
              st.phase = svsw_pkg::PH_SKIP;
              skip_set_byte(b);
            end else if (st.str_cnt == st.wanted) begin
              st.phase = svsw_pkg::PH_EMIT;
              st.chars_sent = 9'd0;
            end else begin
              st.phase = svsw_pkg::PH_STR_IN;
              st.prev_zero = 1'b0;
            end
          end
          svsw_pkg::PH_STR_IN: begin
            if (b == 8'd0) begin
              st.str_cnt = st.str_cnt + 8'd1;
              st.phase = svsw_pkg::PH_STR_START;
              st.prev_zero = 1'b1;
            end else begin
              st.prev_zero = 1'b0;
            end
          end
          svsw_pkg::PH_EMIT: ;
          default: begin
            st.cur_type = b;
            if (b == svsw_pkg::TYPE_END) begin
              have = 1'b1;
              r.done_res = 1'b1;
            end else begin
              st.offset = svsw_pkg::OFS_LENGTH;
              st.phase = svsw_pkg::PH_FORMAT;
            end
          end
        endcase

        // The selected string goes out one character per byte.
        if (st.phase == svsw_pkg::PH_EMIT && !have) begin
          limit = max_len - 9'd1;
          have = 1'b1;
          hit = 1'b1;
          if (b == 8'd0 || st.chars_sent >= limit) begin
            r.done_res = 1'b1;
          end else begin
            r.char_valid = 1'b1;
            r.vendor_char = b;
            st.chars_sent = st.chars_sent + 9'd1;
            r.done_res = (st.chars_sent >= limit) || last;
          end
        end
      end

      // The table end closes a search that is still open.
      if (!have && last) begin
        have = 1'b1;
        r.done_res = 1'b1;
      end
      if (!have) return;
      r.found = r.done_res & hit;
      expected_words.push_back(r);
      if (r.done_res) begin
        if (last) st = svsw_pkg::WALK_REARM;
        else st.finished = 1'b1;
      end
    endfunction

    function void check_word(svsw_pkg::walk_result_t got);
      svsw_pkg::walk_result_t want;
      if (expected_words.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result word: char %h valid %b done %b found %b",
                   got.vendor_char, got.char_valid, got.done_res, got.found);
        return;
      end
      want = expected_words.pop_front();
      if (got.vendor_char !== want.vendor_char || got.char_valid !== want.char_valid ||
          got.done_res !== want.done_res || got.found !== want.found) begin
        fails++;
        if (fails <= 10)
          $display({"result mismatch: expected char %h valid %b done %b found %b, ",
                    "got char %h valid %b done %b found %b"},
                   want.vendor_char, want.char_valid, want.done_res, want.found,
                   got.vendor_char, got.char_valid, got.done_res, got.found);
      end
    endfunction
  endclass

  vendor_scoreboard sb;

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Note each accepted table byte.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_ch.valid && in_ch.ready)
      sb.note_byte(in_ch.table_byte, in_ch.table_last);
  end

  // Check each accepted result word.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid && out_ch.ready)
      sb.check_word('{vendor_char: out_ch.vendor_char, char_valid: out_ch.char_valid,
                      done_res: out_ch.done_res, found: out_ch.found});
  end

  // Result side: random stalls, quiet stretches, and one long hold-off on request.
  initial begin : receiver
    int stall_left;
    int mode_left;
    int roll;
    bit quiet;
    stall_left = 0;
    mode_left = 0;
    quiet = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (pressure_req) begin
        stall_left = PRESSURE_CYCLES;
        pressure_req = 1'b0;
      end
      if (mode_left == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 200);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = (roll < 97) ? $urandom_range(0, 2) : $urandom_range(7, 29);
        end
      end
    end
  end

  // Offer one table byte after a random gap and wait until it is taken.
  task automatic send_byte(logic [7:0] b, logic last, bit busy);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (busy || roll < 70) gap = 0;
    else if (roll < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.table_byte <= b;
    in_ch.table_last <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Send the whole table, flagging its final byte; some tables go without gaps.
  task automatic send_table();
    bit busy;
    busy = ($urandom_range(0, 3) == 0);
    foreach (tbl[i]) send_byte(tbl[i], i == tbl.size() - 1, busy);
  endtask

  // Change the buffer size once the walker has drained.
  task automatic write_buffer_size(logic [8:0] v);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_max_len(v);
  endtask

  // Build a random table: mostly well-formed structures, some noise, some cut short.
  task automatic build_table();
    int kind;
    int len;
    int nstr;
    int slen;
    int cut;
    logic [7:0] typ;
    tbl.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 20)) tbl.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      typ = ($urandom_range(0, 99) < 55) ? svsw_pkg::TYPE_BIOS : 8'($urandom_range(1, 255));
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(0, 3);
        1, 2:    len = $urandom_range(9, 40);
        default: len = $urandom_range(4, 8);
      endcase
      tbl.push_back(typ);
      tbl.push_back(8'(len));
      for (int i = 2; i < len; i++) begin
        if (typ == svsw_pkg::TYPE_BIOS && i == int'(svsw_pkg::OFS_VENDOR))
          tbl.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)));
        else
          tbl.push_back(8'($urandom));
      end
      // String set: a few strings, rarely a long one, closed by an extra zero.
      nstr = $urandom_range(0, 4);
      for (int s = 0; s < nstr; s++) begin
        slen = ($urandom_range(0, 39) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 8);
        repeat (slen) tbl.push_back(8'($urandom_range(1, 255)));
        tbl.push_back(8'd0);
      end
      tbl.push_back(8'd0);
      if (nstr == 0) tbl.push_back(8'd0);
    end
    if ($urandom_range(0, 2) == 0) begin
      tbl.push_back(svsw_pkg::TYPE_END);
      tbl.push_back(svsw_pkg::MIN_LENGTH);
      repeat (4) tbl.push_back(8'd0);
    end
    if (kind <= 2) begin
      cut = $urandom_range(1, tbl.size());
      while (tbl.size() > cut) void'(tbl.pop_back());
    end
  endtask

  initial begin : stimulus
    logic [8:0]  len_plan[PHASE_COUNT];
    int unsigned target;
    len_plan = '{svsw_pkg::MAX_LEN_RESET, 9'd1, 9'd256, 9'd2,
                 9'($urandom_range(3, 40)), 9'd5, svsw_pkg::MAX_LEN_RESET};
    sb = new();
    in_ch.valid = 1'b0;
    in_ch.table_byte = 8'd0;
    in_ch.table_last = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 9'd0;
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // End-of-table type on its own.
    tbl = '{svsw_pkg::TYPE_END};
    send_table();
    // Length below the minimum.
    tbl = '{8'hFF, 8'd2};
    send_table();
    // Second string selected, ended by its zero; the rest is ignored.
    tbl = '{svsw_pkg::TYPE_BIOS, svsw_pkg::MIN_BIOS_LEN, 8'hFF, 8'h80, 8'd2, 8'h41, 8'd0,
            8'h56, 8'd0, 8'd0};
    send_table();
    // Empty string set skipped, then a vendor string cut by the table end.
    tbl = '{svsw_pkg::TYPE_BIOS, svsw_pkg::MIN_BIOS_LEN, 8'd0, 8'd0, 8'd2, 8'd0, 8'd0,
            svsw_pkg::TYPE_BIOS, svsw_pkg::MIN_BIOS_LEN, 8'd0, 8'd0, 8'd1, 8'h7F, 8'hFF};
    send_table();

    // Random tables under several buffer sizes.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p > 0) write_buffer_size(len_plan[p]);
      if (p == 0) pressure_req = 1'b1;
      if (len_plan[p] > 9'd128) begin
        tbl = '{svsw_pkg::TYPE_BIOS, svsw_pkg::MIN_BIOS_LEN, 8'd0, 8'd0, 8'd1};
        repeat (LONG_STRING) tbl.push_back(8'($urandom_range(1, 255)));
        tbl.push_back(8'd0);
        tbl.push_back(8'd0);
        send_table();
      end
      target = (p + 1) * PHASE_WORDS;
      while (sb.walked < target) begin
        build_table();
        send_table();
      end
    end

    // Drain and finish.
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fails == 0) begin
      $display("smbios_vendor_string_walk_test: done, clean");
    end else begin
      $display("smbios_vendor_string_walk_test: done, errors");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("smbios_vendor_string_walk_test: done, errors");
    $finish;
  end

endmodule
